### rtl/ook_command_waveform_generator_top_assert.svh
// ----------------------------------------------------------------------------
// ook command waveform generator assertion macros
// shared property forms for the waveform generator checks
// ----------------------------------------------------------------------------
`ifndef OOK_COMMAND_WAVEFORM_GENERATOR_TOP_ASSERT_SVH
`define OOK_COMMAND_WAVEFORM_GENERATOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define OOK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ook_pkg.sv
// ----------------------------------------------------------------------------
// ook_pkg
// types, constants and pattern functions of the ook waveform generator
// ----------------------------------------------------------------------------
package ook_pkg;

    // payload and register types
    typedef logic [3:0]  dir_t;
    typedef logic [11:0] spb_t;
    typedef logic [6:0]  sample_t;

    // command opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // idle command code and pattern geometry
    localparam dir_t       IDLE_DIR   = 4'd8;
    localparam logic [8:0] LONG_BITS  = 9'd16;
    localparam logic [8:0] IDLE_LEN   = 9'd3;

    // short pulse count per command code
    localparam logic [6:0] SHORT_PULSES [8] = '{
        7'd10, 7'd28, 7'd34, 7'd58, 7'd64, 7'd40, 7'd52, 7'd46
    };

    // scaling: floor(ones * 1143 / 200) as ones * ceil(1143 * 2^16 / 200) >> 16
    localparam int unsigned  ONES_EXT_W   = 7;
    localparam int unsigned  SCALE_MULT_W = 19;
    localparam logic [18:0]  SCALE_MULT   = 19'd374539;
    localparam int unsigned  SCALE_SHIFT  = 16;
    localparam int unsigned  SCALE_PROD_W = ONES_EXT_W + SCALE_MULT_W;
    localparam int unsigned  SCALED_W     = SCALE_PROD_W - SCALE_SHIFT;
    localparam logic [9:0]   SAMPLE_MAX   = 10'd127;

    // control of one window cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    // control of one position counter
    typedef struct packed {
        logic load;
        logic step;
    } pos_ctl_t;

    // pattern length before the maximum length cut
    function automatic logic [8:0] pattern_len_raw(dir_t dir);
        if (dir >= IDLE_DIR)
        begin
            return IDLE_LEN;
        end
        return LONG_BITS + {1'b0, SHORT_PULSES[dir[2:0]], 1'b0};
    endfunction

    // pattern bit at a given bit index
    function automatic logic pattern_bit(dir_t dir, logic [7:0] idx);
        if (dir >= IDLE_DIR)
        begin
            return 1'b0;
        end
        if (idx < 8'd16)
        begin
            return (idx[1:0] != 2'b11);
        end
        return !idx[0];
    endfunction

endpackage

### rtl/ook_tap_cell.sv
// ----------------------------------------------------------------------------
// ook_tap_cell
// one window cell: holds the pattern bit of one sample position
// ----------------------------------------------------------------------------
module ook_tap_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ook_pkg::cell_ctl_t ctl,
    input  logic              shift_in,
    output logic              bit_out
);
    import ook_pkg::*;

    logic bit_reg;
    logic bit_next;

    // clear on refill start, take the neighbor's bit on shift
    always_comb
    begin
        bit_next = bit_reg;
        if (ctl.clear)
        begin
            bit_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            bit_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign bit_out = bit_reg;

endmodule

### rtl/ook_pos_counter.sv
// ----------------------------------------------------------------------------
// ook_pos_counter
// sample position counter: bit index and phase within the bit
// ----------------------------------------------------------------------------
module ook_pos_counter #(
    parameter int IDX_W = 8,
    parameter int LEN_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ook_pkg::pos_ctl_t ctl,
    input  logic [IDX_W-1:0]  load_idx,
    input  ook_pkg::spb_t     load_ph,
    input  logic [LEN_W-1:0]  len,
    input  ook_pkg::spb_t     spb,
    output logic [IDX_W-1:0]  idx,
    output ook_pkg::spb_t     ph
);
    import ook_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    spb_t             ph_reg;
    spb_t             ph_next;

    logic [12:0]      ph_inc;
    logic [IDX_W:0]   idx_inc;
    logic             bit_end;
    logic             wrap;

    // advance by one sample position
    assign ph_inc  = {1'b0, ph_reg} + 13'd1;
    assign bit_end = (ph_inc >= {1'b0, spb});
    assign idx_inc = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign wrap    = (idx_inc >= (IDX_W+1)'(len));

    always_comb
    begin
        idx_next = idx_reg;
        ph_next  = ph_reg;
        if (ctl.load)
        begin
            idx_next = load_idx;
            ph_next  = load_ph;
        end
        else if (ctl.step)
        begin
            if (bit_end)
            begin
                ph_next  = '0;
                idx_next = wrap ? '0 : idx_inc[IDX_W-1:0];
            end
            else
            begin
                ph_next = ph_inc[11:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ph_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            ph_reg  <= ph_next;
        end
    end

    assign idx = idx_reg;
    assign ph  = ph_reg;

endmodule

### rtl/ook_command_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// ook_command_waveform_generator_top
// on-off keyed command waveform generator with a shifting bit window
// ----------------------------------------------------------------------------
// a sample tick transfer shows its registered sample in the next cycle
// throughput: one command per cycle while cmd_ready is high, the window shifts one cell per tick
// after reset, a register write or a direction change the window refills
//   cell by cell from the lookahead counter, cmd_ready low meanwhile
// reset: idle command, position zero, samples_per_bit one, no sample pending
module ook_command_waveform_generator_top #(
    parameter int FILTER_TAPS      = 20,
    parameter int MAX_PATTERN_BITS = 144
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic             op,
    input  ook_pkg::dir_t    direction,
    input  logic             cfg_we,
    input  ook_pkg::spb_t    cfg_wdata,
    output logic             sample_valid,
    input  logic             sample_ready,
    output ook_pkg::sample_t sample
);
    import ook_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATTERN_BITS);
    localparam int LEN_W = $clog2(MAX_PATTERN_BITS + 1);
    localparam int CNT_W = $clog2(FILTER_TAPS + 1);

    // registers
    spb_t             spb_reg;
    dir_t             dir_reg;
    dir_t             dir_next;
    logic [CNT_W-1:0] fill_cnt_reg;
    logic [CNT_W-1:0] fill_cnt_next;
    logic [CNT_W-1:0] ones_cnt_reg;
    logic [CNT_W-1:0] ones_cnt_next;
    logic             sample_valid_reg;
    logic             sample_valid_next;
    sample_t          sample_reg;
    sample_t          sample_next;

    // control
    logic             cmd_xfer;
    logic             tick;
    logic             set_cmd;
    dir_t             dir_in;
    logic             dir_change;
    logic             restart;
    logic             filled;
    logic             fill_step;
    logic             shift;
    spb_t             spb_eff;
    logic [8:0]       len_raw;
    logic [LEN_W-1:0] len;
    logic             new_bit;

    // position counters
    pos_ctl_t         head_ctl;
    pos_ctl_t         gen_ctl;
    logic [IDX_W-1:0] head_idx;
    spb_t             head_ph;
    logic [IDX_W-1:0] gen_idx;
    spb_t             gen_ph;
    logic [IDX_W-1:0] gen_load_idx;
    spb_t             gen_load_ph;

    // window chain
    cell_ctl_t        cell_ctl;
    logic [FILTER_TAPS:0] chain;

    // scaling
    logic [ONES_EXT_W-1:0]   ones_ext;
    logic [SCALE_PROD_W-1:0] prod;
    logic [SCALED_W-1:0]     scaled;

    // command decode
    assign cmd_xfer   = cmd_valid && cmd_ready;
    assign tick       = cmd_xfer && (op == OP_TICK);
    assign set_cmd    = cmd_xfer && (op == OP_SET);
    assign dir_in     = (direction > IDLE_DIR) ? IDLE_DIR : direction;
    assign dir_change = set_cmd && (dir_in != dir_reg);
    assign restart    = dir_change || cfg_we;

    // window fill control
    assign filled    = (fill_cnt_reg == CNT_W'(FILTER_TAPS));
    assign fill_step = !filled && !restart;
    assign shift     = (tick || fill_step) && !restart;
    assign cmd_ready = filled && (!sample_valid_reg || sample_ready);

    // pattern geometry
    assign spb_eff = (spb_reg == '0) ? 12'd1 : spb_reg;
    assign len_raw = pattern_len_raw(dir_reg);
    assign len     = (len_raw > 9'(MAX_PATTERN_BITS)) ? LEN_W'(MAX_PATTERN_BITS)
                                                       : LEN_W'(len_raw);

    // head tracks the current position, the generator runs a window ahead
    assign head_ctl.load = dir_change;
    assign head_ctl.step = tick;
    assign gen_ctl.load  = restart;
    assign gen_ctl.step  = shift;
    assign gen_load_idx  = dir_change ? '0 : head_idx;
    assign gen_load_ph   = dir_change ? '0 : head_ph;

    ook_pos_counter #(
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_head_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (head_ctl),
        .load_idx ('0),
        .load_ph  ('0),
        .len      (len),
        .spb      (spb_eff),
        .idx      (head_idx),
        .ph       (head_ph)
    );

    ook_pos_counter #(
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_gen_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (gen_ctl),
        .load_idx (gen_load_idx),
        .load_ph  (gen_load_ph),
        .len      (len),
        .spb      (spb_eff),
        .idx      (gen_idx),
        .ph       (gen_ph)
    );

    // bit entering the far end of the window
    assign new_bit = pattern_bit(dir_reg, 8'(gen_idx));

    // row of window cells, cell 0 holds the current position
    assign cell_ctl.clear        = restart;
    assign cell_ctl.shift        = shift;
    assign chain[FILTER_TAPS]    = new_bit;

    for (genvar i = 0; i < FILTER_TAPS; i++)
    begin : g_cell
        ook_tap_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .shift_in (chain[i+1]),
            .bit_out  (chain[i])
        );
    end

    // running ones count over the window
    always_comb
    begin
        ones_cnt_next = ones_cnt_reg;
        if (restart)
        begin
            ones_cnt_next = '0;
        end
        else if (shift)
        begin
            if (new_bit && !chain[0])
            begin
                ones_cnt_next = ones_cnt_reg + CNT_W'(1);
            end
            else if (!new_bit && chain[0])
            begin
                ones_cnt_next = ones_cnt_reg - CNT_W'(1);
            end
        end
    end

    // fill counter and direction
    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (restart)
        begin
            fill_cnt_next = '0;
        end
        else if (fill_step)
        begin
            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
        end
    end

    assign dir_next = dir_change ? dir_in : dir_reg;

    // scale the ones count, saturate at full scale
    assign ones_ext = ONES_EXT_W'(ones_cnt_reg);
    assign prod     = {{SCALE_MULT_W{1'b0}}, ones_ext} * {{ONES_EXT_W{1'b0}}, SCALE_MULT};
    assign scaled   = prod[SCALE_PROD_W-1:SCALE_SHIFT];

    // output register
    always_comb
    begin
        sample_valid_next = sample_valid_reg;
        sample_next       = sample_reg;
        if (tick)
        begin
            sample_valid_next = 1'b1;
            sample_next       = (scaled > SAMPLE_MAX) ? SAMPLE_MAX[6:0] : scaled[6:0];
        end
        else if (sample_ready)
        begin
            sample_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg          <= 12'd1;
            dir_reg          <= IDLE_DIR;
            fill_cnt_reg     <= '0;
            ones_cnt_reg     <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                spb_reg <= cfg_wdata;
            end
            dir_reg          <= dir_next;
            fill_cnt_reg     <= fill_cnt_next;
            ones_cnt_reg     <= ones_cnt_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

    // checks
`include "ook_command_waveform_generator_top_assert.svh"

    `OOK_ASSERT_NEXT(a_tick_gives_sample, tick, sample_valid_reg, "tick without sample")
    `OOK_ASSERT_NEXT(a_dir_change_restarts, dir_change,
        (fill_cnt_reg == '0) && (head_idx == '0), "direction change did not restart")
    `OOK_ASSERT_SAME(a_ones_in_range, 1'b1, ones_cnt_reg <= CNT_W'(FILTER_TAPS),
        "ones count exceeds window length")
    `OOK_ASSERT_SAME(a_no_tick_while_filling, !filled, !tick, "tick during window refill")

endmodule

### dv/ook_command_waveform_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ook_command_waveform_generator_top_tb
// drives direction sets and sample ticks into the waveform generator, mirrors
// the pattern position and the 20-sample lookahead filter on the side, and
// checks every sample transfer against the mirrored value, across several
// bit lengths with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module ook_command_waveform_generator_top_tb;

    import ook_pkg::*;

    localparam int TAPS          = 20;
    localparam int MAX_BITS      = 144;
    localparam int SETTLE_CYCLES = 2 * TAPS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SHORT_COUNT [8] = '{10, 28, 34, 58, 64, 40, 52, 46};

    typedef struct packed {
        logic op;
        dir_t dir;
    } cmd_item_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    cmd_valid    = 1'b0;
    logic    cmd_ready;
    logic    op           = OP_TICK;
    dir_t    direction    = IDLE_DIR;
    logic    cfg_we       = 1'b0;
    spb_t    cfg_wdata    = '0;
    logic    sample_valid;
    logic    sample_ready = 1'b0;
    sample_t sample;

    // stimulus and expectations
    cmd_item_t cmd_pending [$];
    sample_t   expected_samples [$];
    int        error_count = 0;
    bit        idle_enable = 1'b1;
    int        hold_req    = 0;
    int        hold_ack    = 0;

    // mirrored generator state
    dir_t       cur_dir   = IDLE_DIR;
    logic [7:0] pos_bit   = '0;
    logic [11:0] pos_phase = '0;
    spb_t       spb_reg   = 12'd1;

    ook_command_waveform_generator_top #(
        .FILTER_TAPS      (TAPS),
        .MAX_PATTERN_BITS (MAX_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .op           (op),
        .direction    (direction),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // pattern length of a command, cut at the maximum
    function automatic logic [8:0] cmd_pattern_len(dir_t dir);
        int n;
        if (dir >= IDLE_DIR)
        begin
            return 9'd3;
        end
        n = 16 + 2 * SHORT_COUNT[dir[2:0]];
        if (n > MAX_BITS)
        begin
            n = MAX_BITS;
        end
        return n[8:0];
    endfunction

    // one bit of a command pattern: long pulses then short pulses
    function automatic logic cmd_pattern_bit(dir_t dir, logic [7:0] idx);
        logic [7:0] rel;
        if (dir >= IDLE_DIR)
        begin
            return 1'b0;
        end
        if (idx < 8'd16)
        begin
            return (idx[1:0] != 2'b11);
        end
        rel = idx - 8'd16;
        return !rel[0];
    endfunction

    // move one sample position forward
    function automatic void step_position(inout logic [7:0] idx, inout logic [11:0] ph,
                                          input logic [8:0] len, input logic [11:0] spb);
        if ({1'b0, ph} + 13'd1 >= {1'b0, spb})
        begin
            ph = '0;
            if ({1'b0, idx} + 9'd1 >= len)
            begin
                idx = '0;
            end
            else
            begin
                idx = idx + 8'd1;
            end
        end
        else
        begin
            ph = ph + 12'd1;
        end
    endfunction

    // filtered sample of one tick, advances the mirrored position
    function automatic sample_t lookahead_sample();
        logic [8:0]  len;
        logic [11:0] spb;
        logic [7:0]  idx;
        logic [11:0] ph;
        int unsigned ones;
        int unsigned scaled;
        int          j;
        len = cmd_pattern_len(cur_dir);
        spb = (spb_reg == 12'd0) ? 12'd1 : spb_reg;
        if ({1'b0, pos_bit} >= len)
        begin
            pos_bit = '0;
        end
        idx  = pos_bit;
        ph   = pos_phase;
        ones = 0;
        for (j = 0; j < TAPS; j++)
        begin
            ones += cmd_pattern_bit(cur_dir, idx);
            step_position(idx, ph, len, spb);
        end
        scaled = ones * 1143 / 200;
        if (scaled > 127)
        begin
            scaled = 127;
        end
        step_position(pos_bit, pos_phase, len, spb);
        return scaled[6:0];
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_cmd(input logic op_v, input dir_t dir_v);
        cmd_item_t item;
        item.op  = op_v;
        item.dir = dir_v;
        cmd_pending = {cmd_pending, item};
    endtask

    // well-formed runs (a set then ticks) mixed with loose items
    task automatic add_random(input int n_items);
        int   count;
        int   run;
        int   k;
        dir_t dir_v;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    dir_v = dir_t'($urandom_range(0, 15));
                end
                else
                begin
                    dir_v = dir_t'($urandom_range(0, 7));
                end
                push_cmd(OP_SET, dir_v);
                if ($urandom_range(0, 9) == 0)
                begin
                    run = $urandom_range(100, 170);
                end
                else
                begin
                    run = $urandom_range(1, 40);
                end
                // keep the phase at its item count
                if (run > n_items - count - 1)
                begin
                    run = n_items - count - 1;
                end
                for (k = 0; k < run; k++)
                begin
                    push_cmd(OP_TICK, dir_t'($urandom_range(0, 15)));
                end
                count += run + 1;
            end
            else
            begin
                push_cmd($urandom_range(0, 1) ? OP_SET : OP_TICK, dir_t'($urandom_range(0, 15)));
                count++;
            end
        end
    endtask

    // wait until every item is in and every sample is out
    task automatic drain();
        while (cmd_pending.size() != 0 || cmd_valid || expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // register write once the generator is quiet
    task automatic write_spb(input spb_t value);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // command driver with random gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        int        gap_cnt;
        cmd_item_t item;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_cnt = 0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (gap_cnt > 0)
            begin
                gap_cnt--;
                cmd_valid <= 1'b0;
            end
            else if (cmd_pending.size() > 0)
            begin
                item = cmd_pending.pop_front();
                cmd_valid <= 1'b1;
                op        <= item.op;
                direction <= item.dir;
                if (idle_enable && $urandom_range(0, 7) == 0)
                begin
                    gap_cnt = $urandom_range(1, 12);
                end
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // sample receiver: random stall bursts and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin : sample_receiver
        int stall_cnt;
        if (!rst_n)
        begin
            sample_ready <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                stall_cnt = HOLD_CYCLES;
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                sample_ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                stall_cnt = $urandom_range(0, 11);
                sample_ready <= 1'b0;
            end
            else
            begin
                sample_ready <= 1'b1;
            end
        end
    end

    // monitor: mirror register writes and command transfers, check samples
    always @(posedge clk)
    begin : monitor
        dir_t    dir_v;
        sample_t exp_v;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                spb_reg = cfg_wdata;
            end
            if (cmd_valid && cmd_ready)
            begin
                if (op == OP_SET)
                begin
                    // codes above the idle command fold onto it
                    dir_v = (direction > IDLE_DIR) ? IDLE_DIR : direction;
                    if (dir_v != cur_dir)
                    begin
                        cur_dir   = dir_v;
                        pos_bit   = '0;
                        pos_phase = '0;
                    end
                end
                else
                begin
                    exp_v = lookahead_sample();
                    expected_samples = {expected_samples, exp_v};
                end
            end
            if (sample_valid && sample_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_error($sformatf("sample transfer %0d with nothing expected", sample));
                end
                else
                begin
                    exp_v = expected_samples.pop_front();
                    if (sample !== exp_v)
                    begin
                        note_error($sformatf("sample mismatch: expected %0d, got %0d",
                                             exp_v, sample));
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // sequence of phases
    initial
    begin
        int d;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // shortest bits, directed items first
        write_spb(12'd1);
        push_cmd(OP_TICK, 4'hF);
        push_cmd(OP_TICK, 4'h0);
        for (d = 0; d < 8; d++)
        begin
            push_cmd(OP_SET, dir_t'(d));
            push_cmd(OP_TICK, dir_t'(d));
        end
        // same direction again changes nothing
        push_cmd(OP_SET, dir_t'(7));
        push_cmd(OP_TICK, 4'h0);
        // out of range codes act as idle
        push_cmd(OP_SET, 4'hF);
        push_cmd(OP_TICK, 4'h5);
        push_cmd(OP_SET, dir_t'(0));
        push_cmd(OP_SET, 4'h9);
        push_cmd(OP_TICK, 4'hA);
        add_random(110);

        // zero bit length, with a long receiver hold-off
        write_spb(12'd0);
        add_random(50);
        hold_req++;

        // longest bits, left mid-bit for the next phase
        write_spb(12'hFFF);
        add_random(30);

        // bit length shrunk below the running phase
        write_spb(12'd3);
        add_random(50);

        write_spb(spb_t'($urandom_range(2, 9)));
        add_random(50);

        write_spb(spb_t'($urandom_range(0, 4095)));
        add_random(40);

        // last part with no idling on either side
        write_spb(12'd1);
        idle_enable = 1'b0;
        add_random(50);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_samples.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
